FILE: design/tcpg_pkg.sv
// ----------------------------------------------------------------------------
// tcpg_pkg
// Shared constants, codes and stage types of the text cell pixel generator.
// ----------------------------------------------------------------------------
package tcpg_pkg;

    // Cell and screen geometry
    localparam int CELL_LINES     = 8;
    localparam int CELL_PIXELS    = 8;
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_ROWS    = 32;

    // Glyph store
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GLYPH_W     = 8;

    // Colours and pixel row
    localparam int COLOR_W = 3;
    localparam int ROW_W   = CELL_PIXELS * COLOR_W;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd0;

    // Blink phase counter
    localparam int BLINK_W = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ROW = 1'b1;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_RENDER = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    // Decode stage contents
    typedef struct packed {
        logic               valid;
        func_t              kind;
        logic [ADDR_W-1:0]  addr;
        logic [GLYPH_W-1:0] wdata;
        logic               cursor_hit;
        logic [7:0]         attrib;
        logic [8:0]         pixel_x;
        logic [7:0]         pixel_y;
    } s1_t;

    // Glyph fetch stage contents
    typedef struct packed {
        logic               valid;
        logic               cursor_white;
        logic [COLOR_W-1:0] on_color;
        logic [COLOR_W-1:0] bg_color;
        logic [8:0]         pixel_x;
        logic [7:0]         pixel_y;
    } s2_t;

endpackage

FILE: design/tcpg_if.sv
// ----------------------------------------------------------------------------
// tcpg_if
// Valid/ready channels: command items in, rendered pixel rows out.
// ----------------------------------------------------------------------------
interface tcpg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] scan_line;
    logic [7:0] char_code;
    logic [7:0] attrib;
    logic [9:0] rom_addr;
    logic [7:0] rom_data;

    modport source (
        output valid, func, cell_x, cell_y, scan_line, char_code, attrib,
               rom_addr, rom_data,
        input  ready
    );
    modport sink (
        input  valid, func, cell_x, cell_y, scan_line, char_code, attrib,
               rom_addr, rom_data,
        output ready
    );
endinterface

interface tcpg_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_row;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;

    modport source (
        output valid, pixel_row, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, pixel_x, pixel_y,
        output ready
    );
endinterface

FILE: design/text_cell_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// text_cell_pixel_generator_core
// Path: an item is registered in the decode stage, then in the glyph stage,
// then in the output register, from which its result leaves.
// Throughput: one item per cycle unless stalled, set by the single glyph store
// port that each item uses at most once in the second stage.
// Reset: valid bits, blink phase and cursor registers clear; the glyph
// store is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
module text_cell_pixel_generator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    tcpg_cmd_if.sink                           cmd,
    tcpg_pix_if.source                         pix,
    input  logic                               cfg_we,
    input  logic [tcpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_wdata
);

    logic [7:0]                   cursor_col_reg;
    logic [7:0]                   cursor_row_reg;
    tcpg_pkg::s1_t                s1;
    tcpg_pkg::s2_t                s2;
    logic [tcpg_pkg::GLYPH_W-1:0] glyph_bits;
    logic                         glyph_ready;
    logic                         expand_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcpg_pkg::CFG_CURSOR_COL: cursor_col_reg <= cfg_wdata;
                tcpg_pkg::CFG_CURSOR_ROW: cursor_row_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: decode
    tcpg_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cursor_col (cursor_col_reg),
        .cursor_row (cursor_row_reg),
        .down_ready (glyph_ready),
        .s1         (s1)
    );

    // Stage 2: glyph store and blink
    tcpg_glyph u_glyph (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1         (s1),
        .up_ready   (glyph_ready),
        .down_ready (expand_ready),
        .s2         (s2),
        .glyph_bits (glyph_bits)
    );

    // Stage 3: pixel expansion and output register
    tcpg_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2         (s2),
        .glyph_bits (glyph_bits),
        .up_ready   (expand_ready),
        .pix        (pix)
    );

endmodule

FILE: design/tcpg_decode.sv
// ----------------------------------------------------------------------------
// tcpg_decode
// First stage: decodes the item, forms the glyph store address and the
// cursor match, and registers the result.
// ----------------------------------------------------------------------------
module tcpg_decode (
    input  logic              clk,
    input  logic              rst_n,
    tcpg_cmd_if.sink          cmd,
    input  logic [7:0]        cursor_col,
    input  logic [7:0]        cursor_row,
    input  logic              down_ready,
    output tcpg_pkg::s1_t     s1
);

    tcpg_pkg::s1_t s1_reg;
    tcpg_pkg::s1_t s1_next;
    logic [2:0]    line_sel;
    logic          on_screen;

    // Stage frees up when empty or when its contents move on
    assign cmd.ready = !s1_reg.valid || down_ready;

    // Decode
    always_comb
    begin
        // double height: top half on even rows, bottom half on odd rows
        line_sel  = cmd.char_code[7] ? {cmd.cell_y[0], cmd.scan_line[2:1]}
                                     : cmd.scan_line;
        on_screen = (cursor_col < 8'(tcpg_pkg::SCREEN_COLUMNS)) &&
                    (cursor_row < 8'(tcpg_pkg::SCREEN_ROWS));

        s1_next            = '0;
        s1_next.wdata      = cmd.rom_data;
        s1_next.attrib     = cmd.attrib;
        s1_next.pixel_x    = {cmd.cell_x, 3'b000};
        s1_next.pixel_y    = {cmd.cell_y, cmd.scan_line};
        s1_next.cursor_hit = on_screen &&
                             (cursor_col == {2'b00, cmd.cell_x}) &&
                             (cursor_row == {3'b000, cmd.cell_y});
        s1_next.addr       = {cmd.char_code[6:0], line_sel};
        case (cmd.func)
            tcpg_pkg::FUNC_WRITE:
            begin
                s1_next.valid = cmd.valid;
                s1_next.kind  = tcpg_pkg::FUNC_WRITE;
                s1_next.addr  = cmd.rom_addr;
            end
            tcpg_pkg::FUNC_RENDER:
            begin
                s1_next.valid = cmd.valid;
                s1_next.kind  = tcpg_pkg::FUNC_RENDER;
            end
            tcpg_pkg::FUNC_TICK:
            begin
                s1_next.valid = cmd.valid;
                s1_next.kind  = tcpg_pkg::FUNC_TICK;
            end
            default:
            begin
                // unused code: dropped on transfer
                s1_next.valid = 1'b0;
                s1_next.kind  = tcpg_pkg::FUNC_TICK;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (cmd.ready)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

FILE: design/tcpg_glyph.sv
// ----------------------------------------------------------------------------
// tcpg_glyph
// Second stage: glyph store access (write or read, at most one per item), blink
// phase counter and colour selection.
// ----------------------------------------------------------------------------
module tcpg_glyph (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcpg_pkg::s1_t                    s1,
    output logic                             up_ready,
    input  logic                             down_ready,
    output tcpg_pkg::s2_t                    s2,
    output logic [tcpg_pkg::GLYPH_W-1:0]     glyph_bits
);

    logic [tcpg_pkg::GLYPH_W-1:0] store_mem [tcpg_pkg::STORE_DEPTH];
    logic [tcpg_pkg::GLYPH_W-1:0] glyph_bits_reg;
    logic [tcpg_pkg::BLINK_W-1:0] blink_phase_reg;
    tcpg_pkg::s2_t                s2_reg;
    logic                         adv;
    logic                         blink_on;

    assign up_ready = !s2_reg.valid || down_ready;
    assign adv      = s1.valid && up_ready;
    // blink on for even phases
    assign blink_on = !blink_phase_reg[0];

    // Blink phase and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_phase_reg <= '0;
            s2_reg          <= '0;
        end
        else
        begin
            if (adv && s1.kind == tcpg_pkg::FUNC_TICK)
            begin
                blink_phase_reg <= blink_phase_reg + 4'd1;
            end
            if (up_ready)
            begin
                s2_reg.valid        <= s1.valid && s1.kind == tcpg_pkg::FUNC_RENDER;
                s2_reg.cursor_white <= blink_on && s1.cursor_hit;
                s2_reg.on_color     <= (s1.attrib[7] && blink_on) ?
                                       tcpg_pkg::COLOR_BLACK : s1.attrib[2:0];
                s2_reg.bg_color     <= s1.attrib[5:3];
                s2_reg.pixel_x      <= s1.pixel_x;
                s2_reg.pixel_y      <= s1.pixel_y;
            end
        end
    end

    // Glyph store: at most one access per transfer, read data held while stalled
    always_ff @(posedge clk)
    begin
        if (adv && s1.kind == tcpg_pkg::FUNC_WRITE)
        begin
            store_mem[s1.addr] <= s1.wdata;
        end
        if (adv && s1.kind == tcpg_pkg::FUNC_RENDER)
        begin
            glyph_bits_reg <= store_mem[s1.addr];
        end
    end

    assign s2         = s2_reg;
    assign glyph_bits = glyph_bits_reg;

`ifndef NO_ASSERTIONS
    // A frame tick moves the blink phase on by one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1.kind == tcpg_pkg::FUNC_TICK
        |=> blink_phase_reg == $past(blink_phase_reg) + 4'd1)
        else $error("blink phase did not advance on tick");

    // Nothing but a tick changes the blink phase
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && s1.kind == tcpg_pkg::FUNC_TICK) |=> $stable(blink_phase_reg))
        else $error("blink phase changed without tick");

    // Writes and ticks never produce a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1.kind != tcpg_pkg::FUNC_RENDER |=> !s2_reg.valid)
        else $error("non-render item produced a result");
`endif

endmodule

FILE: design/tcpg_expand.sv
// ----------------------------------------------------------------------------
// tcpg_expand
// Third stage: expands the glyph line into eight colours, or all white for a
// cursor cell, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tcpg_expand (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcpg_pkg::s2_t                    s2,
    input  logic [tcpg_pkg::GLYPH_W-1:0]     glyph_bits,
    output logic                             up_ready,
    tcpg_pix_if.source                       pix
);

    logic                          valid_reg;
    logic [tcpg_pkg::ROW_W-1:0]    row_reg;
    logic [tcpg_pkg::ROW_W-1:0]    row_next;
    logic [8:0]                    pixel_x_reg;
    logic [7:0]                    pixel_y_reg;

    assign up_ready = !valid_reg || pix.ready;

    // Pixel expansion, leftmost pixel in the top bits
    always_comb
    begin
        row_next = '0;
        for (int k = 0; k < tcpg_pkg::CELL_PIXELS; k++)
        begin
            row_next[tcpg_pkg::ROW_W-1-k*tcpg_pkg::COLOR_W -: tcpg_pkg::COLOR_W] =
                glyph_bits[tcpg_pkg::CELL_PIXELS-1-k] ? s2.on_color : s2.bg_color;
        end
        if (s2.cursor_white)
        begin
            row_next = '1;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= s2.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (up_ready && s2.valid)
        begin
            row_reg     <= row_next;
            pixel_x_reg <= s2.pixel_x;
            pixel_y_reg <= s2.pixel_y;
        end
    end

    assign pix.valid     = valid_reg;
    assign pix.pixel_row = row_reg;
    assign pix.pixel_x   = pixel_x_reg;
    assign pix.pixel_y   = pixel_y_reg;

`ifndef NO_ASSERTIONS
    // A cursor cell comes out all white
    a_cursor_white: assert property (@(posedge clk) disable iff (!rst_n)
        up_ready && s2.valid && s2.cursor_white |=> row_reg == '1)
        else $error("cursor cell not rendered white");
`endif

endmodule
